[sv/sss_pkg.sv]
`timescale 1ns / 1ps

package sss_pkg;

    // Position and field widths
    localparam int POSITION_WIDTH = 24;
    localparam int DEST_WIDTH     = 24;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int STEP_INCREMENT = 4;
    localparam int SAMPLE_RESET   = 48;

    // Working width for sums before saturation
    localparam int CALC_WIDTH =
        ((POSITION_WIDTH > DEST_WIDTH) ? POSITION_WIDTH : DEST_WIDTH) + 2;

    typedef logic signed [POSITION_WIDTH-1:0] pos_t;
    typedef logic signed [CALC_WIDTH-1:0]     calc_t;
    typedef logic        [SAMPLE_WIDTH-1:0]   sample_cnt_t;

    typedef enum logic [1:0] {
        OP_START       = 2'd0,
        OP_TICK        = 2'd1,
        OP_SAMPLE_DONE = 2'd2,
        OP_ABORT       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_MOVE = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    typedef struct packed {
        op_t                           operation;
        logic signed [DEST_WIDTH-1:0]  destination;
        logic                          scan_enable;
        logic                          limit_high;
        logic                          limit_low;
    } item_t;

    typedef struct packed {
        logic step_pulse;
        logic step_direction;
        pos_t position;
        logic sample_request;
        logic busy_res;
        logic limit_hit;
    } result_t;

    // Saturate a wide signed value to the position range
    function automatic pos_t clamp_pos(calc_t v);
        pos_t maxp;
        pos_t minp;
        maxp = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
        minp = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
        if (v > calc_t'(maxp)) begin
            return maxp;
        end
        else if (v < calc_t'(minp)) begin
            return minp;
        end
        else begin
            return v[POSITION_WIDTH-1:0];
        end
    endfunction

endpackage

[sv/sss_in_stage.sv]
`timescale 1ns / 1ps

module sss_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sss_pkg::item_t in_item,
    input  logic          take,
    output logic          item_valid,
    output sss_pkg::item_t item
);
    import sss_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Slot is free when empty or drained this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end
        else if (take) begin
            valid_next = 1'b0;
        end
        else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/sss_ctrl.sv]
`timescale 1ns / 1ps

module sss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  sss_pkg::sample_cnt_t cfg_data,
    input  logic                 fire,
    input  sss_pkg::item_t       item,
    output sss_pkg::result_t     res
);
    import sss_pkg::*;

    // Sequencer state
    pos_t        pos_reg,     pos_next;
    pos_t        final_reg,   final_next;
    pos_t        seg_reg,     seg_next;
    logic        up_reg,      up_next;
    logic        scan_reg,    scan_next;
    phase_t      phase_reg,   phase_next;
    sample_cnt_t sbs_reg;

    // Decoded conditions
    pos_t        dest;
    logic        dest_at_pos;
    logic        start_up;
    logic        start_lim;
    logic        lim_ahead;
    pos_t        tgt;
    logic        reach_before;
    logic        step_ok;
    pos_t        pos_stepped;
    pos_t        pos_after;
    logic        reach_after;
    logic        reach_final_after;
    sample_cnt_t seg_len;
    pos_t        seg_from_pos;

    logic        pulse;
    logic        req;
    logic        hit;

    // Shared compares and adders
    always_comb
    begin
        dest        = clamp_pos(calc_t'(item.destination));
        dest_at_pos = (dest == pos_reg);
        start_up    = (dest > pos_reg);
        start_lim   = start_up ? item.limit_high : item.limit_low;
        lim_ahead   = up_reg ? item.limit_high : item.limit_low;
        tgt         = scan_reg ? seg_reg : final_reg;
        reach_before = up_reg ? (pos_reg >= tgt) : (pos_reg <= tgt);
        step_ok     = !reach_before && !lim_ahead;
        pos_stepped = up_reg
                    ? clamp_pos(calc_t'(pos_reg) + calc_t'(STEP_INCREMENT))
                    : clamp_pos(calc_t'(pos_reg) - calc_t'(STEP_INCREMENT));
        pos_after   = step_ok ? pos_stepped : pos_reg;
        reach_after = up_reg ? (pos_after >= tgt) : (pos_after <= tgt);
        reach_final_after = up_reg ? (pos_after >= final_reg)
                                   : (pos_after <= final_reg);
        // zero segment length counts as one
        seg_len     = (sbs_reg == '0) ? sample_cnt_t'(1) : sbs_reg;
        seg_from_pos = up_reg
                     ? clamp_pos(calc_t'(pos_reg) + calc_t'(seg_len))
                     : clamp_pos(calc_t'(pos_reg) - calc_t'(seg_len));
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (item.operation)
            OP_START:
            begin
                if (dest_at_pos) begin
                    phase_next = PH_IDLE;
                end
                else if (!item.scan_enable) begin
                    phase_next = PH_MOVE;
                end
                else if (start_lim) begin
                    phase_next = PH_IDLE;
                end
                else begin
                    phase_next = PH_WAIT;
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_MOVE) begin
                    priority if (!reach_before && lim_ahead) begin
                        phase_next = PH_IDLE;
                    end
                    else if (reach_after) begin
                        if (!scan_reg || reach_final_after || lim_ahead) begin
                            phase_next = PH_IDLE;
                        end
                        else begin
                            phase_next = PH_WAIT;
                        end
                    end
                    else begin
                        phase_next = PH_MOVE;
                    end
                end
            end
            OP_SAMPLE_DONE:
            begin
                if (phase_reg == PH_WAIT) begin
                    phase_next = PH_MOVE;
                end
            end
            OP_ABORT:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Datapath updates and result flags
    always_comb
    begin
        pos_next   = pos_reg;
        final_next = final_reg;
        seg_next   = seg_reg;
        up_next    = up_reg;
        scan_next  = scan_reg;
        pulse      = 1'b0;
        req        = 1'b0;
        hit        = 1'b0;
        unique case (item.operation)
            OP_START:
            begin
                final_next = dest;
                seg_next   = dest;
                scan_next  = item.scan_enable;
                if (!dest_at_pos) begin
                    up_next = start_up;
                    hit     = item.scan_enable && start_lim;
                    req     = item.scan_enable && !start_lim;
                end
            end
            OP_TICK:
            begin
                if (phase_reg == PH_MOVE) begin
                    pos_next = pos_after;
                    pulse    = step_ok;
                    hit = lim_ahead && (!reach_before
                          || (reach_after && scan_reg && !reach_final_after));
                    req = !lim_ahead && reach_after && scan_reg
                          && !reach_final_after;
                end
            end
            OP_SAMPLE_DONE:
            begin
                if (phase_reg == PH_WAIT) begin
                    seg_next = seg_from_pos;
                end
            end
            OP_ABORT:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            final_reg <= '0;
            seg_reg   <= '0;
            up_reg    <= 1'b0;
            scan_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
        end
        else if (fire) begin
            pos_reg   <= pos_next;
            final_reg <= final_next;
            seg_reg   <= seg_next;
            up_reg    <= up_next;
            scan_reg  <= scan_next;
            phase_reg <= phase_next;
        end
    end

    // Segment length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sbs_reg <= sample_cnt_t'(SAMPLE_RESET);
        end
        else if (cfg_we) begin
            sbs_reg <= cfg_data;
        end
    end

    assign res.step_pulse     = pulse;
    assign res.step_direction = up_next;
    assign res.position       = pos_next;
    assign res.sample_request = req;
    assign res.busy_res       = (phase_next != PH_IDLE);
    assign res.limit_hit      = hit;

    // A step is only issued by a tick while moving
    a_pulse_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.step_pulse |-> phase_reg == PH_MOVE
                                   && item.operation == OP_TICK)
        else $error("step issued outside a move");

    // A sample request leaves the sequencer waiting
    a_req_waits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.sample_request |=> phase_reg == PH_WAIT)
        else $error("sample request without wait");

    // Abort always idles
    a_abort_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_ABORT |=> phase_reg == PH_IDLE)
        else $error("abort did not idle");

    // Limit stop ends motion
    a_hit_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.limit_hit |-> !res.busy_res && !res.step_pulse)
        else $error("limit hit while still busy");

endmodule

[sv/stepper_stage_move_scan.sv]
`timescale 1ns / 1ps
// Stepper stage sequencer with optional sampling scan.
// Input channel (in_valid/in_ready) carries one item: operation (start, tick,
// sample done, abort), destination, scan_enable and the two limit switches.
// Every accepted item yields exactly one result item on the output channel
// (out_valid/out_ready): step pulse, direction, position in quarter steps,
// sample request, busy and limit-hit flags.
// Items pass an input register, then the sequencer logic writes its state and
// the result register at the same clock edge: out_valid rises once an accepted
// item has passed the input register and the result register, and one item per
// cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// takes one more item; in_ready then drops until out_ready returns.
// Config channel (cfg_valid/cfg_ready, always ready) writes
// steps_between_samples; write it only while no item is in flight.
// Reset clears position, targets and direction, leaves the block idle with
// both channels empty and loads a segment length of 48 quarter steps.

module stepper_stage_move_scan (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             operation,
    input  logic signed [sss_pkg::DEST_WIDTH-1:0]  destination,
    input  logic                                   scan_enable,
    input  logic                                   limit_high,
    input  logic                                   limit_low,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   step_pulse,
    output logic                                   step_direction,
    output logic signed [sss_pkg::POSITION_WIDTH-1:0] position,
    output logic                                   sample_request,
    output logic                                   busy_res,
    output logic                                   limit_hit,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sss_pkg::SAMPLE_WIDTH-1:0]       steps_between_samples
);
    import sss_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // Pack the input fields
    assign in_item.operation   = op_t'(operation);
    assign in_item.destination = destination;
    assign in_item.scan_enable = scan_enable;
    assign in_item.limit_high  = limit_high;
    assign in_item.limit_low   = limit_low;

    // Advance when the result register is free or being drained
    assign take      = item_valid && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    sss_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (steps_between_samples),
        .fire     (take),
        .item     (item),
        .res      (res)
    );

    // Result register
    always_comb
    begin
        if (take) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_pulse     = res_reg.step_pulse;
    assign step_direction = res_reg.step_direction;
    assign position       = res_reg.position;
    assign sample_request = res_reg.sample_request;
    assign busy_res       = res_reg.busy_res;
    assign limit_hit      = res_reg.limit_hit;

endmodule
